>>> hw/rtl/gcdisp_pkg.sv
// ----------------------------------------------------------------------------
// gcdisp_pkg: shared types and constants of the greedy change dispenser
// Slot count, field widths, status codes, reset denominations, cell links.
// ----------------------------------------------------------------------------
package gcdisp_pkg;

    localparam int SLOTS = 5;
    localparam int CNT_W = 16;
    localparam int DEN_W = 10;
    localparam int IDX_W = 3;
    localparam int PRD_W = CNT_W + DEN_W;

    // result status codes
    localparam logic [1:0] ST_DISPENSED = 2'd0;
    localparam logic [1:0] ST_SHORT     = 2'd1;
    localparam logic [1:0] ST_LOADED    = 2'd2;

    // input command codes
    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_DISPENSE = 1'b1;

    localparam logic [DEN_W-1:0] DENOM_RESET [SLOTS] = '{
        10'd100, 10'd50, 10'd20, 10'd5, 10'd1
    };

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIN
    } t_top_state;

    typedef enum logic [2:0] {
        C_IDLE,
        C_DIV,
        C_CLIP,
        C_SUB,
        C_DONE
    } t_cell_state;

    // remaining amount handed from one cell to the next
    typedef struct packed {
        logic             go;
        logic [CNT_W-1:0] rest;
    } t_link;

    // end-of-item stock update for one cell
    typedef struct packed {
        logic             load;
        logic             apply;
        logic [CNT_W-1:0] count;
    } t_commit;

endpackage

>>> hw/rtl/gcdisp_cell.sv
// ----------------------------------------------------------------------------
// gcdisp_cell: one denomination slot of the dispenser chain
// Holds the slot's stock, divides the incoming amount by the denomination
// one quotient bit per cycle, clips to stock and passes the rest onward.
// ----------------------------------------------------------------------------
module gcdisp_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  gcdisp_pkg::t_link          i_link,
    input  logic [gcdisp_pkg::DEN_W-1:0] i_denom,
    input  gcdisp_pkg::t_commit        i_commit,
    output gcdisp_pkg::t_link          o_link,
    output logic [gcdisp_pkg::CNT_W-1:0] o_take,
    output logic [gcdisp_pkg::CNT_W-1:0] o_stock
);
    import gcdisp_pkg::*;

    localparam int CW = $clog2(CNT_W);
    localparam logic [CW-1:0] LAST_BIT = CW'(CNT_W - 1);

    t_cell_state      r_state, n_state;
    logic [CW-1:0]    r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [CNT_W-1:0] r_quo;
    logic [CNT_W-1:0] r_rest_in;
    logic [CNT_W-1:0] r_take;
    logic [PRD_W-1:0] r_prod;
    logic [CNT_W-1:0] r_rest_out;
    logic [CNT_W-1:0] r_stock, n_stock;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_diff;
    logic             rem_ge;

    // restoring division step
    assign rem_sh   = {r_rem, r_quo[CNT_W-1]};
    assign rem_diff = rem_sh - {1'b0, i_denom};
    assign rem_ge   = (rem_sh >= {1'b0, i_denom});

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE: begin
                if (i_link.go) begin
                    n_state = (i_denom == '0) ? C_DONE : C_DIV;
                end
            end
            C_DIV: begin
                if (r_cnt == LAST_BIT) begin
                    n_state = C_CLIP;
                end
            end
            C_CLIP: n_state = (r_quo > r_stock) ? C_SUB : C_DONE;
            C_SUB:  n_state = C_DONE;
            C_DONE: n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_link.go   = (r_state == C_DONE);
        o_link.rest = r_rest_out;
        o_take      = r_take;
        o_stock     = n_stock;
    end

    // stock update at the end of an item
    always_comb begin
        priority if (i_commit.load) begin
            n_stock = i_commit.count;
        end else if (i_commit.apply) begin
            n_stock = r_stock - r_take;
        end else begin
            n_stock = r_stock;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_stock <= '0;
        end else begin
            r_state <= n_state;
            r_stock <= n_stock;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            C_IDLE: begin
                // take the amount only when the previous cell hands it over;
                // the take stays put until the item commits
                if (i_link.go) begin
                    r_quo      <= i_link.rest;
                    r_rest_in  <= i_link.rest;
                    r_rem      <= '0;
                    r_cnt      <= '0;
                    r_take     <= '0;
                    r_rest_out <= i_link.rest;
                end
            end
            C_DIV: begin
                r_rem <= rem_ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                r_quo <= {r_quo[CNT_W-2:0], rem_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            C_CLIP: begin
                if (r_quo > r_stock) begin
                    r_take <= r_stock;
                    r_prod <= r_stock * i_denom;
                end else begin
                    r_take     <= r_quo;
                    r_rest_out <= CNT_W'(r_rem);
                end
            end
            C_SUB: begin
                r_rest_out <= r_rest_in - r_prod[CNT_W-1:0];
            end
            C_DONE: begin
                r_rem <= r_rem;
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

endmodule

>>> hw/rtl/greedy_change_dispenser.sv
// A load goes from acceptance straight to the result stage. A dispense walks the
// five slot cells in turn: a zero-valued slot just passes the amount on, else the
// cell divides bit-serially and clips to stock, multiplying back when clipped.
// One word in work at a time; the next word is taken once the result is registered,
// and a stalled result port holds the sequencer in S_FIN until the slot frees.
// Reset (synchronous, active low) clears all stock and restores 100, 50, 20, 5, 1.
// ----------------------------------------------------------------------------
// greedy_change_dispenser: limited-stock greedy change maker
// Top level: stream ports, denomination registers, sequencer and result stage
// over a chain of five slot cells.
// ----------------------------------------------------------------------------
module greedy_change_dispenser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input word
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [2:0] slot, [18:3] value, zero pad
    input  logic [0:0]  i_s_axis_tuser,   // [0] cmd
    // result word
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [87:0] o_m_axis_tdata,   // take_0..take_4 16 bits each, [80] empty
    output logic [1:0]  o_m_axis_tuser,   // [1:0] status
    // configuration
    input  logic        i_cfg_we,
    input  logic [gcdisp_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [gcdisp_pkg::DEN_W-1:0] i_cfg_data
);
    import gcdisp_pkg::*;

    t_top_state       r_state, n_state;
    logic [DEN_W-1:0] r_denom [SLOTS];
    logic             r_cmd;
    logic [IDX_W-1:0] r_slot;
    logic [CNT_W-1:0] r_value;
    logic [CNT_W-1:0] r_rest_fin;

    logic             r_out_valid;
    logic [1:0]       r_status;
    logic [CNT_W-1:0] r_take [SLOTS];
    logic             r_empty;

    t_link            link [SLOTS+1];
    t_commit          commit [SLOTS];
    logic [CNT_W-1:0] cell_take [SLOTS];
    logic [CNT_W-1:0] cell_stock [SLOTS];

    logic             in_acc;
    logic             slot_free;
    logic             commit_en;
    logic             ok;
    logic             empty_after;

    assign in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign slot_free = !r_out_valid || i_m_axis_tready;
    assign commit_en = (r_state == S_FIN) && slot_free;
    assign ok        = (r_rest_fin == '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_s_axis_tuser[0] == CMD_DISPENSE) ? S_RUN : S_FIN;
                end
            end
            S_RUN: begin
                if (link[SLOTS].go) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_s_axis_tready = (r_state == S_IDLE);
        link[0].go      = in_acc && (i_s_axis_tuser[0] == CMD_DISPENSE);
        link[0].rest    = i_s_axis_tdata[18:3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // denomination registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_denom[i] <= DENOM_RESET[i];
            end
        end else if (i_cfg_we) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (i_cfg_idx == IDX_W'(i)) begin
                    r_denom[i] <= i_cfg_data;
                end
            end
        end
    end

    // captured input word and final remainder
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd   <= i_s_axis_tuser[0];
            r_slot  <= i_s_axis_tdata[2:0];
            r_value <= i_s_axis_tdata[18:3];
        end
        if (link[SLOTS].go) begin
            r_rest_fin <= link[SLOTS].rest;
        end
    end

    // cell chain
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        always_comb begin
            commit[g].load  = commit_en && (r_cmd == CMD_LOAD) && (r_slot == IDX_W'(g));
            commit[g].apply = commit_en && (r_cmd == CMD_DISPENSE) && ok;
            commit[g].count = r_value;
        end

        gcdisp_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_link   (link[g]),
            .i_denom  (r_denom[g]),
            .i_commit (commit[g]),
            .o_link   (link[g+1]),
            .o_take   (cell_take[g]),
            .o_stock  (cell_stock[g])
        );
    end

    // empty flag from the stock after this item
    always_comb begin
        empty_after = 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
            if (cell_stock[i] != '0) begin
                empty_after = 1'b0;
            end
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit_en) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit_en) begin
            r_empty <= empty_after;
            if (r_cmd == CMD_LOAD) begin
                r_status <= ST_LOADED;
            end else if (ok) begin
                r_status <= ST_DISPENSED;
            end else begin
                r_status <= ST_SHORT;
            end
            for (int i = 0; i < SLOTS; i++) begin
                r_take[i] <= ((r_cmd == CMD_DISPENSE) && ok) ? cell_take[i] : '0;
            end
        end
    end

    always_comb begin
        o_m_axis_tvalid = r_out_valid;
        o_m_axis_tuser  = r_status;
        o_m_axis_tdata  = '0;
        for (int i = 0; i < SLOTS; i++) begin
            o_m_axis_tdata[i*CNT_W +: CNT_W] = r_take[i];
        end
        o_m_axis_tdata[SLOTS*CNT_W] = r_empty;
    end

endmodule

>>> hw/rtl/gcdisp_chk.sv
// ----------------------------------------------------------------------------
// gcdisp_chk: port-level checks of the greedy change dispenser
// Watches the stream ports and flags impossible results or handshake slips.
// ----------------------------------------------------------------------------
module gcdisp_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [87:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);
    import gcdisp_pkg::*;

    // status is always one of the three defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser == ST_DISPENSED ||
                             o_m_axis_tuser == ST_SHORT ||
                             o_m_axis_tuser == ST_LOADED))
        else $error("result status code out of range");

    // only a successful dispense reports pieces
    a_take_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != ST_DISPENSED)
            |-> (o_m_axis_tdata[79:0] == '0))
        else $error("pieces reported without a dispense");

    // one word in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input taken while a word is in work");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready)
            |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind greedy_change_dispenser gcdisp_chk u_gcdisp_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
